>>> rtl/core/pcdu_pkg.sv
package pcdu_pkg;

  localparam logic [1:0] OP_VALIDATE = 2'd0;
  localparam logic [1:0] OP_NEXT     = 2'd1;
  localparam logic [1:0] OP_PREV     = 2'd2;
  localparam logic [1:0] OP_BETWEEN  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  localparam logic [0:0] REG_LOWER = 1'b0;
  localparam logic [0:0] REG_UPPER = 1'b1;

  localparam logic [31:0] LOWER_RESET = 32'h076C_0101;
  localparam logic [31:0] UPPER_RESET = 32'h0833_0C1F;

  // floor(y / 100) = (y * K100) >> K100_SHIFT for y < 2^16
  localparam logic [16:0] K100       = 17'd83887;
  localparam int          K100_SHIFT = 23;
  localparam logic [15:0] CENTURY    = 16'd100;
  localparam logic [24:0] YEAR_DAYS  = 25'd365;

  localparam int DAYNUM_W = 25;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] date_a;
    logic [31:0] date_b;
  } pcdu_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        valid_flag;
    logic [31:0] date_out;
    logic [24:0] day_count;
  } pcdu_res_t;

  typedef struct packed {
    logic [31:0] lower;
    logic [31:0] upper;
  } pcdu_bounds_t;

  typedef struct packed {
    logic                ok;
    logic [4:0]          len;
    logic [4:0]          prev_len;
    logic [DAYNUM_W-1:0] day_num;
  } pcdu_dinfo_t;

  function automatic logic [4:0] month_len(input logic [7:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: len = 5'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    len = 5'd30;
      8'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [7:0] m);
    logic [8:0] n;
    case (m)
      8'd2:    n = 9'd31;
      8'd3:    n = 9'd59;
      8'd4:    n = 9'd90;
      8'd5:    n = 9'd120;
      8'd6:    n = 9'd151;
      8'd7:    n = 9'd181;
      8'd8:    n = 9'd212;
      8'd9:    n = 9'd243;
      8'd10:   n = 9'd273;
      8'd11:   n = 9'd304;
      8'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/core/pcdu_apb_regs.sv
module pcdu_apb_regs
  import pcdu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output pcdu_bounds_t bounds_o
);

  logic [31:0] lower_q, upper_q;
  logic        wr_en;
  logic [0:0]  sel;

  assign pready = 1'b1;
  assign sel    = paddr[2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RESET;
      upper_q <= UPPER_RESET;
    end else if (wr_en) begin
      case (sel)
        REG_LOWER: lower_q <= pwdata;
        REG_UPPER: upper_q <= pwdata;
        default:   lower_q <= lower_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_LOWER: prdata = lower_q;
      REG_UPPER: prdata = upper_q;
      default:   prdata = '0;
    endcase
  end

  assign bounds_o.lower = lower_q;
  assign bounds_o.upper = upper_q;

endmodule

>>> rtl/core/pcdu_day_num.sv
module pcdu_day_num
  import pcdu_pkg::*;
(
  input  logic        clk_i,
  input  logic [31:0] date_i,
  output pcdu_dinfo_t info_o
);

  // stage 1: year products
  logic [15:0] y_s1_q;
  logic [7:0]  m_s1_q, d_s1_q;
  logic [9:0]  q_s1_q;
  logic [24:0] y365_s1_q;
  logic [32:0] qprod;

  assign qprod = 33'(date_i[31:16]) * 33'(K100);

  always_ff @(posedge clk_i) begin
    y_s1_q    <= date_i[31:16];
    m_s1_q    <= date_i[15:8];
    d_s1_q    <= date_i[7:0];
    q_s1_q    <= qprod[K100_SHIFT+9:K100_SHIFT];
    y365_s1_q <= 25'(date_i[31:16]) * YEAR_DAYS;
  end

  // stage 2: leap rule, legality, year base and day of year
  logic [15:0]         r16;
  logic                div100, div400, leap;
  logic [4:0]          len, prev_len;
  logic                ok;
  logic [DAYNUM_W-1:0] base;
  logic [8:0]          doy;

  assign r16    = y_s1_q - (16'(q_s1_q) * CENTURY);
  assign div100 = (r16 == 16'd0);
  assign div400 = div100 && (q_s1_q[1:0] == 2'd0);
  assign leap   = ((y_s1_q[1:0] == 2'd0) && !div100) || div400;
  assign len      = month_len(m_s1_q, leap);
  assign prev_len = month_len(m_s1_q - 8'd1, leap);
  assign ok     = (len != 5'd0) && (d_s1_q != 8'd0) && (d_s1_q <= 8'(len));
  assign base   = y365_s1_q + 25'(y_s1_q[15:2]) + 25'(y_s1_q[1:0] != 2'd0)
                - 25'(q_s1_q) - 25'(!div100) + 25'(q_s1_q[9:2]) + 25'(!div400);
  assign doy    = days_before_month(m_s1_q) + 9'((m_s1_q > 8'd2) && leap)
                + 9'(d_s1_q) - 9'd1;

  logic                ok_s2_q;
  logic [4:0]          len_s2_q, prev_len_s2_q;
  logic [DAYNUM_W-1:0] base_s2_q;
  logic [8:0]          doy_s2_q;

  always_ff @(posedge clk_i) begin
    ok_s2_q       <= ok;
    len_s2_q      <= len;
    prev_len_s2_q <= prev_len;
    base_s2_q     <= base;
    doy_s2_q      <= doy;
  end

  // stage 3: day number
  pcdu_dinfo_t info_s3_q;

  always_ff @(posedge clk_i) begin
    info_s3_q.ok       <= ok_s2_q;
    info_s3_q.len      <= len_s2_q;
    info_s3_q.prev_len <= prev_len_s2_q;
    info_s3_q.day_num  <= base_s2_q + DAYNUM_W'(doy_s2_q);
  end

  assign info_o = info_s3_q;

endmodule

>>> rtl/core/packed_calendar_date_unit_core.sv
// Packed Gregorian date unit. Dates are words: year 31..16, month 15..8,
// day 7..0. Each command word on cmd_i selects validate, next day, previous
// day or days between; it is taken at a rising edge with start high and
// busy low. busy stays low: a new word can be taken every cycle.
// Every command gives exactly one result word on res_o, flagged by a
// one-cycle res_valid_o strobe. The word passes three date pipeline
// stages plus the output register, the first of them loaded at the
// accepting edge. The receiver cannot stall; results leave in command
// order, one per cycle at most.
// Bound registers sit on the APB port: lower at 0x0, upper at 0x4. pready
// is tied high. Write them only while no command is in flight.
// Reset clears the pipeline valid bits and the output strobe and loads the
// bounds with Jan 1 1900 and Dec 31 2099.
module packed_calendar_date_unit_core
  import pcdu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  pcdu_cmd_t   cmd_i,
  output logic        res_valid_o,
  output pcdu_res_t   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pcdu_bounds_t bounds;
  pcdu_dinfo_t  info_a, info_b;
  logic         accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  pcdu_apb_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .bounds_o (bounds)
  );

  pcdu_day_num u_dn_a (
    .clk_i  (clk_i),
    .date_i (cmd_i.date_a),
    .info_o (info_a)
  );

  pcdu_day_num u_dn_b (
    .clk_i  (clk_i),
    .date_i (cmd_i.date_b),
    .info_o (info_b)
  );

  // command pipeline alongside the date units
  logic      v_s1_q, v_s2_q, v_s3_q;
  pcdu_cmd_t cmd_s1_q, cmd_s2_q, cmd_s3_q;
  logic      inr_s1_q, inr_s2_q, inr_s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s1_q <= 1'b0;
      v_s2_q <= 1'b0;
      v_s3_q <= 1'b0;
    end else begin
      v_s1_q <= accept;
      v_s2_q <= v_s1_q;
      v_s3_q <= v_s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_s1_q <= cmd_i;
    inr_s1_q <= (cmd_i.date_a >= bounds.lower) && (cmd_i.date_a <= bounds.upper);
    cmd_s2_q <= cmd_s1_q;
    inr_s2_q <= inr_s1_q;
    cmd_s3_q <= cmd_s2_q;
    inr_s3_q <= inr_s2_q;
  end

  // stage 4: result select
  logic [15:0] y;
  logic [7:0]  m, d;
  logic [31:0] next_date, prev_date;
  pcdu_res_t   res_d, res_q;
  logic        res_valid_q;

  assign y = cmd_s3_q.date_a[31:16];
  assign m = cmd_s3_q.date_a[15:8];
  assign d = cmd_s3_q.date_a[7:0];

  always_comb begin
    if (d == 8'(info_a.len)) begin
      if (m == 8'd12) begin
        next_date = {y + 16'd1, 8'd1, 8'd1};
      end else begin
        next_date = {y, m + 8'd1, 8'd1};
      end
    end else begin
      next_date = cmd_s3_q.date_a + 32'd1;
    end
    if (d == 8'd1 && m == 8'd1) begin
      prev_date = {y - 16'd1, 8'd12, 8'd31};
    end else if (d == 8'd1) begin
      prev_date = {y, m - 8'd1, 8'(info_a.prev_len)};
    end else begin
      prev_date = cmd_s3_q.date_a - 32'd1;
    end
  end

  always_comb begin
    res_d = '0;
    case (cmd_s3_q.opcode)
      OP_VALIDATE: res_d.valid_flag = inr_s3_q && info_a.ok;
      OP_NEXT: begin
        if (!info_a.ok) begin
          res_d.status   = ST_BAD;
          res_d.date_out = cmd_s3_q.date_a;
        end else begin
          res_d.date_out = next_date;
        end
      end
      OP_PREV: begin
        if (!info_a.ok) begin
          res_d.status   = ST_BAD;
          res_d.date_out = cmd_s3_q.date_a;
        end else begin
          res_d.date_out = prev_date;
        end
      end
      OP_BETWEEN: begin
        if (!info_a.ok || !info_b.ok) begin
          res_d.status = ST_BAD;
        end else if (cmd_s3_q.date_b < cmd_s3_q.date_a) begin
          res_d.status = ST_ORDER;
        end else begin
          res_d.day_count = info_b.day_num - info_a.day_num;
        end
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= v_s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 res_valid_o)
    else $error("accepted word produced no result");

  a_result_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, 4))
    else $error("result without a command");

  a_validate_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.opcode == OP_VALIDATE) |-> ##4 (res_o.status == ST_OK))
    else $error("validate returned an error status");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != ST_OK) |->
      (res_o.day_count == '0 && !res_o.valid_flag))
    else $error("error result carries a count or valid flag");

endmodule
